/* rtl/pgs_pkg.sv */
// Package for the programmable GF(2^8) substitution box.
// Holds the sequencer state type, register indexes, reset values and the
// circulant affine and degree functions; depends on nothing.
`default_nettype none

package pgs_pkg;

  typedef enum logic [1:0] {
    EU_IDLE,
    EU_RUN,
    EU_DONE
  } eu_state_e;

  typedef enum logic [2:0] {
    CFG_MODULUS     = 3'd0,
    CFG_FWD_SEED    = 3'd1,
    CFG_FWD_CONST   = 3'd2,
    CFG_INV_SEED    = 3'd3,
    CFG_INV_CONST   = 3'd4
  } cfg_idx_e;

  localparam logic [8:0] RST_MODULUS   = 9'h11B;
  localparam logic [7:0] RST_FWD_SEED  = 8'hF1;
  localparam logic [7:0] RST_FWD_CONST = 8'h63;
  localparam logic [7:0] RST_INV_SEED  = 8'hA4;
  localparam logic [7:0] RST_INV_CONST = 8'h05;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic       no_inverse;
    logic [7:0] y;
  } inv_status_t;

  function automatic logic [7:0] affine(input logic [7:0] x, input logic [7:0] seed,
                                        input logic [7:0] cst);
    logic [7:0] res;
    logic [2:0] k;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        k = 3'(j - i);
        res[i] = res[i] ^ (seed[k] & x[j]);
      end
    end
    return res ^ cst;
  endfunction

  function automatic logic [3:0] deg9(input logic [8:0] p);
    logic [3:0] d;
    d = '0;
    for (int k = 0; k < 9; k++) begin
      if (p[k]) begin
        d = 4'(k);
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

/* rtl/pgs_euclid.sv */
// Iterative field inverter: polynomial extended Euclid, one step per cycle under a small
// sequencer: a shift-and-reduce, a divisor swap or the closing check. Depends on pgs_pkg.
`default_nettype none

module pgs_euclid (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [7:0]         elem_i,
  input  wire logic [8:0]         modulus_i,
  output pgs_pkg::inv_status_t    status_o
);

  pgs_pkg::eu_state_e state_q, state_d;

  logic [8:0] num_q, num_d;
  logic [7:0] den_q, den_d;
  logic [7:0] ya_q, ya_d;
  logic [7:0] yc_q, yc_d;
  logic       flag_q, flag_d;

  logic [3:0] dn;
  logic [3:0] dd;
  logic [3:0] sh;
  logic       reduce;

  always_comb begin
    dn     = pgs_pkg::deg9(num_q);
    dd     = pgs_pkg::deg9({1'b0, den_q});
    sh     = dn - dd;
    reduce = (num_q != 9'd0) && (dn >= dd);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pgs_pkg::EU_IDLE: begin
        if (start_i) begin
          state_d = (elem_i == 8'd0) ? pgs_pkg::EU_DONE : pgs_pkg::EU_RUN;
        end
      end
      pgs_pkg::EU_RUN: begin
        if (!reduce && (num_q == 9'd0)) begin
          state_d = pgs_pkg::EU_DONE;
        end
      end
      pgs_pkg::EU_DONE: state_d = pgs_pkg::EU_IDLE;
      default:          state_d = pgs_pkg::EU_IDLE;
    endcase
  end

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    ya_d   = ya_q;
    yc_d   = yc_q;
    flag_d = flag_q;
    if ((state_q == pgs_pkg::EU_IDLE) && start_i) begin
      num_d  = modulus_i;
      den_d  = elem_i;
      ya_d   = 8'd0;
      yc_d   = (elem_i != 8'd0) ? 8'd1 : 8'd0;
      flag_d = 1'b0;
    end else if (state_q == pgs_pkg::EU_RUN) begin
      if (reduce) begin
        num_d = num_q ^ ({1'b0, den_q} << sh);
        ya_d  = ya_q ^ (yc_q << sh);
      end else if (num_q == 9'd0) begin
        flag_d = (den_q != 8'd1);
      end else begin
        // advance: remainder becomes divisor, coefficients rotate
        num_d = {1'b0, den_q};
        den_d = num_q[7:0];
        ya_d  = yc_q;
        yc_d  = ya_q;
      end
    end
  end

  always_comb begin
    status_o.busy       = (state_q != pgs_pkg::EU_IDLE);
    status_o.done       = (state_q == pgs_pkg::EU_DONE);
    status_o.no_inverse = flag_q;
    status_o.y          = yc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pgs_pkg::EU_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    ya_q   <= ya_d;
    yc_q   <= yc_d;
    flag_q <= flag_d;
  end

endmodule

`default_nettype wire

/* rtl/programmable_gf256_sbox.sv */
// Top level of the programmable GF(2^8) substitution box: configuration
// registers, affine maps and result word register. Depends on pgs_pkg, pgs_euclid.
//
// channel   direction  handshake            payload
// command   in         start_i / busy_o     op_i, data_in_i
// result    out        result_valid_o       data_out_o, no_inverse_o
// config    in         cfg_we_i             cfg_idx_i, cfg_data_i
//
// A command word is taken when start_i is high and busy_o low.
// The result strobes after the done state and the strobe register; for a nonzero element
// the sequencer first runs Euclid steps: reduce steps, divisor swaps and a closing check.
// busy_o stays high until the result is ready; a new word may be taken in the strobe cycle.
// Reset clears the sequencer and loads the AES configuration; results cannot be stalled.
`default_nettype none

module programmable_gf256_sbox (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic       op_i,
  input  wire logic [7:0] data_in_i,
  output logic            result_valid_o,
  output logic [7:0]      data_out_o,
  output logic            no_inverse_o,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [8:0] cfg_data_i
);

  logic [8:0] modulus_q;
  logic [7:0] fwd_seed_q;
  logic [7:0] fwd_const_q;
  logic [7:0] inv_seed_q;
  logic [7:0] inv_const_q;

  logic       op_q;
  logic       valid_q;
  logic [7:0] data_out_q;
  logic       no_inv_q;

  logic       accept;
  logic [7:0] elem;

  pgs_pkg::inv_status_t status;

  assign busy_o = status.busy;
  assign accept = start_i && !status.busy;
  assign elem   = op_i ? pgs_pkg::affine(data_in_i, inv_seed_q, inv_const_q) : data_in_i;

  pgs_euclid u_euclid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .elem_i    (elem),
    .modulus_i (modulus_q),
    .status_o  (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= pgs_pkg::RST_MODULUS;
      fwd_seed_q  <= pgs_pkg::RST_FWD_SEED;
      fwd_const_q <= pgs_pkg::RST_FWD_CONST;
      inv_seed_q  <= pgs_pkg::RST_INV_SEED;
      inv_const_q <= pgs_pkg::RST_INV_CONST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pgs_pkg::CFG_MODULUS:   modulus_q   <= cfg_data_i;
        pgs_pkg::CFG_FWD_SEED:  fwd_seed_q  <= cfg_data_i[7:0];
        pgs_pkg::CFG_FWD_CONST: fwd_const_q <= cfg_data_i[7:0];
        pgs_pkg::CFG_INV_SEED:  inv_seed_q  <= cfg_data_i[7:0];
        pgs_pkg::CFG_INV_CONST: inv_const_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= status.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_i;
    end
    if (status.done) begin
      data_out_q <= op_q ? status.y : pgs_pkg::affine(status.y, fwd_seed_q, fwd_const_q);
      no_inv_q   <= status.no_inverse;
    end
  end

  assign result_valid_o = valid_q;
  assign data_out_o     = data_out_q;
  assign no_inverse_o   = no_inv_q;

`ifndef SYNTH
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o) else $error("accepted word did not raise busy");
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o) else $error("result strobe while busy");
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe longer than a cycle");
`endif

endmodule

`default_nettype wire
